// ===== hw/rtl/fpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 4;
    localparam int ERR_W     = 2;
    localparam int DIV_W     = DATA_W + FRAC_BITS;  // dividend width

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_CMP  = 4'd4;
    localparam logic [OP_W-1:0] OP_MIN  = 4'd5;
    localparam logic [OP_W-1:0] OP_MAX  = 4'd6;
    localparam logic [OP_W-1:0] OP_FINT = 4'd7;
    localparam logic [OP_W-1:0] OP_TINT = 4'd8;
    localparam logic [OP_W-1:0] OP_INC  = 4'd9;
    localparam logic [OP_W-1:0] OP_DEC  = 4'd10;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
        logic signed [DATA_W-1:0] int_operand;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     less_than;
        logic                     equal_to;
        logic                     greater_than;
        logic [ERR_W-1:0]         error_code;
    } t_res;

    // classified word passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
        logic                     lt;
        logic                     eq;
        logic                     div_zero;
        logic                     range_err;
        logic signed [DATA_W-1:0] quick;      // result of the simple ops
    } t_slot;

endpackage
`default_nettype wire

// ===== hw/rtl/fpa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_cmd_if / fpa_res_if
// Valid/ready channels for command and result words.
// ----------------------------------------------------------------------------
interface fpa_cmd_if;
    import fpa_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fpa_res_if;
    import fpa_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front
// Accepts command words, classifies them, computes the simple ops and
// pushes a slot into a two-entry queue.
// ----------------------------------------------------------------------------
module fpa_front
    import fpa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    fpa_cmd_if.sink      i_cmd,
    input  wire          i_pop,
    output logic         o_q_valid,
    output t_slot        o_q_slot
);

    t_slot             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    t_slot             slot;
    t_cmd              c;
    logic signed [DATA_W-1:0] tint;

    localparam logic signed [DATA_W-1:0] LIM = DATA_W'(1) <<< (DATA_W-1-FRAC_BITS);

    assign c           = i_cmd.payload;
    assign i_cmd.ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH)) || i_pop;
    assign push        = i_cmd.valid && i_cmd.ready;

    always_comb begin
        // round toward zero: bias negatives before the shift
        if (c.operand_a[DATA_W-1]) begin
            tint = (c.operand_a + DATA_W'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
        end else begin
            tint = c.operand_a >>> FRAC_BITS;
        end
        slot.operation = c.operation;
        slot.operand_a = c.operand_a;
        slot.operand_b = c.operand_b;
        slot.lt        = c.operand_a < c.operand_b;
        slot.eq        = c.operand_a == c.operand_b;
        slot.div_zero  = c.operand_b == '0;
        slot.range_err = (c.int_operand >= LIM) || (c.int_operand < -LIM);
        unique case (c.operation)
            OP_ADD:  slot.quick = c.operand_a + c.operand_b;
            OP_SUB:  slot.quick = c.operand_a - c.operand_b;
            OP_MIN:  slot.quick = slot.lt ? c.operand_a : c.operand_b;
            OP_MAX:  slot.quick = (!slot.lt && !slot.eq) ? c.operand_a : c.operand_b;
            OP_FINT: slot.quick = slot.range_err ? '0 : (c.int_operand <<< FRAC_BITS);
            OP_TINT: slot.quick = tint;
            OP_INC:  slot.quick = c.operand_a + DATA_W'(1);
            OP_DEC:  slot.quick = c.operand_a - DATA_W'(1);
            default: slot.quick = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_pop);
        end
    end

    assign o_q_valid = r_count != '0;
    assign o_q_slot  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, on magnitudes.
// Tags ride along so the pipe carries every op, not only divides.
// ----------------------------------------------------------------------------
module fpa_div
    import fpa_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [DIV_W-1:0]     i_num,
    input  wire [DATA_W-1:0]    i_den,
    input  wire                 i_neg,
    input  t_res                i_tag,
    input  wire                 i_is_div,
    output logic                o_valid,
    output t_res                o_res
);

    localparam int STAGES = DIV_W;

    logic               r_v    [STAGES+1];
    logic [DIV_W-1:0]   r_q    [STAGES+1];  // remaining dividend / quotient
    logic [DATA_W:0]    r_rem  [STAGES+1];
    logic [DATA_W-1:0]  r_den  [STAGES+1];
    logic               r_neg  [STAGES+1];
    logic               r_isd  [STAGES+1];
    t_res               r_tag  [STAGES+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_neg[0] = i_neg;
        r_isd[0] = i_is_div;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DATA_W:0] sh;
        logic [DATA_W:0] df;
        always_comb begin
            sh = {r_rem[s][DATA_W-1:0], r_q[s][DIV_W-1]};
            df = sh - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= {r_q[s][DIV_W-2:0], ~df[DATA_W]};
                r_rem[s+1] <= df[DATA_W] ? sh : df;
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_isd[s+1] <= r_isd[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    logic [DATA_W-1:0] qlo;
    assign qlo = r_q[STAGES][DATA_W-1:0];

    always_comb begin
        o_valid = r_v[STAGES];
        o_res   = r_tag[STAGES];
        if (r_isd[STAGES]) begin
            o_res.result_value = r_neg[STAGES] ? -qlo : qlo;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fpa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_back
// Pops slots, runs multiply (registered product) and divide (bit pipe) in one
// in-order pipe, and feeds a skid-buffered output register.
// ----------------------------------------------------------------------------
module fpa_back
    import fpa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_q_valid,
    input  t_slot        i_q_slot,
    output logic         o_pop,
    fpa_res_if.source    o_res
);

    // stage 1: slot register and multiply
    logic               r_v1;
    t_slot              r_s1;
    logic signed [2*DATA_W-1:0] r_prod;
    logic               en;
    logic               pv;
    t_res               pres;

    // output register plus skid
    logic   r_ov, r_sv;
    t_res   r_o, r_sk;

    // pipe advances unless the skid holds a word
    assign en    = !r_sv;
    assign o_pop = en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1   <= i_q_slot;
            r_prod <= 64'(i_q_slot.operand_a) * 64'(i_q_slot.operand_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= i_q_valid;
    end

    // stage 2 inputs to divider pipe
    logic [DATA_W-1:0] ma, mb;
    logic [DIV_W-1:0]  num;
    logic              neg, isd;
    t_res              tag;

    always_comb begin
        ma  = r_s1.operand_a[DATA_W-1] ? -r_s1.operand_a : r_s1.operand_a;
        mb  = r_s1.operand_b[DATA_W-1] ? -r_s1.operand_b : r_s1.operand_b;
        num = {ma, FRAC_BITS'(0)};
        neg = r_s1.operand_a[DATA_W-1] ^ r_s1.operand_b[DATA_W-1];
        isd = (r_s1.operation == OP_DIV) && !r_s1.div_zero;
        tag = '0;
        unique case (r_s1.operation)
            OP_MUL: tag.result_value = DATA_W'(r_prod >>> FRAC_BITS);
            OP_DIV: tag.error_code   = r_s1.div_zero ? ERR_DIV0 : ERR_NONE;
            OP_CMP: begin
                tag.less_than    = r_s1.lt;
                tag.equal_to     = r_s1.eq;
                tag.greater_than = !r_s1.lt && !r_s1.eq;
            end
            OP_FINT: begin
                tag.result_value = r_s1.quick;
                tag.error_code   = r_s1.range_err ? ERR_RANGE : ERR_NONE;
            end
            default: tag.result_value = r_s1.quick;
        endcase
    end

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_num   (num),
        .i_den   (mb),
        .i_neg   (neg),
        .i_tag   (tag),
        .i_is_div(isd),
        .o_valid (pv),
        .o_res   (pres)
    );

    // the pipe output is caught by the output register, or the skid when
    // the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || o_res.ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= pv;
                end
            end else if (en && pv) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_res.ready) begin
            r_o <= r_sv ? r_sk : pres;
        end else if (en) begin
            r_sk <= pres;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.payload = r_o;

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q24.8 ALU: front classifier, two-entry queue, pipelined back end.
// ----------------------------------------------------------------------------
// Every op takes the same path: slot register, divider pipe, output register.
// Throughput: one word per cycle while the result side is ready; all ops share one in-order pipe.
// Reset: synchronous active-low i_rst_n empties queue, pipe and output.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    fpa_cmd_if.sink      i_cmd,
    fpa_res_if.source    o_res
);

    logic  q_valid, pop;
    t_slot q_slot;

    fpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_pop    (pop),
        .o_q_valid(q_valid),
        .o_q_slot (q_slot)
    );

    fpa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_slot (q_slot),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire

// ===== tb/tb_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Drives random and corner-case commands into the fixed-point ALU, predicts
// each result in the testbench and checks results in order, with random
// gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int LATENCY   = DATA_W + FRAC_BITS + 2;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;
    int   cycle = 0;
    int   errors = 0;
    int   cmd_gap_pct;
    int   res_stall_pct;

    fpa_cmd_if cmd_ch ();
    fpa_res_if res_ch ();

    fixed_point_alu u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle);
        errors++;
    endtask

    // predicts the ALU result for one command
    function automatic t_res alu_predict(input t_cmd c);
        t_res r;
        logic signed [63:0] a, b, n, p;
        logic signed [63:0] lim;
        a = c.operand_a;
        b = c.operand_b;
        n = c.int_operand;
        lim = 64'sd1 <<< (31 - FRAC_BITS);
        r = '0;
        case (c.operation)
            OP_ADD: r.result_value = 32'(a + b);
            OP_SUB: r.result_value = 32'(a - b);
            OP_MUL: begin
                p = a * b;
                r.result_value = 32'(p >>> FRAC_BITS);
            end
            OP_DIV: begin
                if (b == 0) r.error_code = ERR_DIV0;
                else r.result_value = 32'((a <<< FRAC_BITS) / b);
            end
            OP_CMP: begin
                r.less_than    = a < b;
                r.equal_to     = a == b;
                r.greater_than = a > b;
            end
            OP_MIN: r.result_value = (a < b) ? c.operand_a : c.operand_b;
            OP_MAX: r.result_value = (a > b) ? c.operand_a : c.operand_b;
            OP_FINT: begin
                if (n >= lim || n < -lim) r.error_code = ERR_RANGE;
                else r.result_value = 32'(n <<< FRAC_BITS);
            end
            OP_TINT: r.result_value = 32'(a / (64'sd1 <<< FRAC_BITS));
            OP_INC: r.result_value = 32'(a + 1);
            OP_DEC: r.result_value = 32'(a - 1);
            default: r = '0;
        endcase
        return r;
    endfunction

    class alu_scoreboard;
        t_res pending[$];
        int   checked;

        function void note_cmd(t_cmd c);
            pending.push_back(alu_predict(c));
        endfunction

        task check_res(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report("unexpected word", got.result_value, 32'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.result_value !== want.result_value)
                report("result_value", got.result_value, want.result_value);
            if (got.less_than !== want.less_than)
                report("less_than", 32'(got.less_than), 32'(want.less_than));
            if (got.equal_to !== want.equal_to)
                report("equal_to", 32'(got.equal_to), 32'(want.equal_to));
            if (got.greater_than !== want.greater_than)
                report("greater_than", 32'(got.greater_than), 32'(want.greater_than));
            if (got.error_code !== want.error_code)
                report("error_code", 32'(got.error_code), 32'(want.error_code));
        endtask
    endclass

    alu_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("fixed_point_alu test failed");
            $finish;
        end
    end

    // result side: random stalls, checks every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_res(res_ch.payload);
        res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'($urandom_range(512)) - 32'd256;
            3: return 32'($urandom_range(1 << 16));
            default: return $urandom();
        endcase
    endfunction

    // sends one command word, honoring the gap rate; valid stays up until
    // the next call decides to idle or to send
    task automatic send_cmd(input t_cmd c);
        while ($urandom_range(99) < cmd_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(c);
    endtask

    task automatic send(input logic [3:0] op, input logic [31:0] a,
                        input logic [31:0] b, input logic [31:0] n);
        t_cmd c;
        c.operation = op;
        c.operand_a = a;
        c.operand_b = b;
        c.int_operand = n;
        send_cmd(c);
    endtask

    task automatic random_phase(input int count);
        t_cmd c;
        logic [31:0] lim;
        lim = 32'd1 << (31 - FRAC_BITS);
        repeat (count) begin
            c.operation = ($urandom_range(19) == 0) ? 4'(11 + $urandom_range(4))
                                                    : 4'($urandom_range(10));
            c.operand_a = rand_word();
            c.operand_b = ($urandom_range(15) == 0) ? 32'd0
                        : ($urandom_range(7) == 0) ? c.operand_a : rand_word();
            case ($urandom_range(3))
                0: c.int_operand = lim - 32'($urandom_range(2));
                1: c.int_operand = -lim - 32'($urandom_range(1)) + 32'd0;
                default: c.int_operand = rand_word();
            endcase
            send_cmd(c);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] lim;
        sb = new();
        lim = 32'd1 << (31 - FRAC_BITS);
        cmd_gap_pct = 25;
        res_stall_pct = 71;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: wraps, divide by zero, division overflow, range edges
        send(OP_ADD, 32'h7FFF_FFFF, 32'd1, 0);
        send(OP_SUB, 32'h8000_0000, 32'd1, 0);
        send(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
        send(OP_MUL, 32'hFFFF_FFFF, 32'd1, 0);
        send(OP_DIV, 32'd100, 32'd0, 0);
        send(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send(OP_DIV, 32'hFFFF_FF00, 32'd3, 0);
        send(OP_CMP, 32'd5, 32'd5, 0);
        send(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(OP_CMP, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(OP_FINT, 0, 0, lim - 1);
        send(OP_FINT, 0, 0, lim);
        send(OP_FINT, 0, 0, -lim);
        send(OP_FINT, 0, 0, -lim - 1);
        send(OP_FINT, 0, 0, 32'hFFFF_FFFF);
        send(OP_TINT, 32'hFFFF_FF01, 0, 0);
        send(OP_TINT, 32'h8000_0000, 0, 0);
        send(OP_INC, 32'h7FFF_FFFF, 0, 0);
        send(OP_DEC, 32'h8000_0000, 0, 0);
        send(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        random_phase(330);
        cmd_gap_pct = 71;
        res_stall_pct = 25;
        random_phase(330);
        cmd_gap_pct = 0;
        res_stall_pct = 0;
        random_phase(340);
        drain();

        $display("checked %0d results over all eleven ops, corners and three", sb.checked);
        $display("flow-control mixes; %0d mismatches", errors);
        if (errors == 0 && sb.pending.size() == 0)
            $display("fixed_point_alu test passed");
        else
            $display("fixed_point_alu test failed");
        $finish;
    end
endmodule
